/* src/gasp_pkg.sv */
package gasp_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_TEX_SIDE = 4096;
    localparam int MAX_GLYPH    = 512;
    localparam int ROW_IDX_W    = $clog2(MAX_ROWS);

    localparam logic [2:0] ST_OLD_ROW   = 3'd0;
    localparam logic [2:0] ST_NEW_ROW   = 3'd1;
    localparam logic [2:0] ST_TOO_WIDE  = 3'd2;
    localparam logic [2:0] ST_AT_MAX    = 3'd3;
    localparam logic [2:0] ST_ROWS_FULL = 3'd4;

    localparam logic CFG_INITIAL_SIDE  = 1'b0;
    localparam logic CFG_FIRST_ROW_TOP = 1'b1;

    // broadcast to every cell
    typedef struct packed {
        logic [9:0]  w;
        logic [13:0] h_x10;      // 10 * glyph height
        logic [12:0] cur_width;
        logic [11:0] wr_top;
        logic [9:0]  wr_height;
        logic [12:0] wr_fill;
    } cell_req_t;

    typedef struct packed {
        logic        hit;
        logic [11:0] x;
        logic [11:0] y;
    } cell_rsp_t;

endpackage

/* src/gasp_cell.sv */
module gasp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_in,
    input  logic                wr_en,
    input  gasp_pkg::cell_req_t req,
    output logic                tok_out,
    output gasp_pkg::cell_rsp_t rsp
);

    logic        tok_reg;
    logic [11:0] top_reg;
    logic [9:0]  height_reg;
    logic [12:0] fill_reg;
    logic [13:0] r_x7;
    logic [13:0] r_x10;
    logic [13:0] fill_sum;
    logic        fits;

    assign r_x7     = {1'b0, height_reg, 3'b000} - {4'b0000, height_reg};
    assign r_x10    = {1'b0, height_reg, 3'b000} + {3'b000, height_reg, 1'b0};
    assign fill_sum = {1'b0, fill_reg} + {4'b0000, req.w};
    assign fits     = !(req.h_x10 < r_x7) && !(req.h_x10 > r_x10)
                      && (fill_sum <= {1'b0, req.cur_width});

    assign rsp.hit = tok_reg && fits;
    assign rsp.x   = rsp.hit ? fill_reg[11:0] : 12'd0;
    assign rsp.y   = rsp.hit ? top_reg : 12'd0;
    assign tok_out = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            top_reg    <= req.wr_top;
            height_reg <= req.wr_height;
            fill_reg   <= req.wr_fill;
        end
        else if (rsp.hit)
        begin
            fill_reg <= fill_sum[12:0];
        end
    end

endmodule

/* src/glyph_atlas_shelf_packer_unit.sv */
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    glyph_width, glyph_height
// out       out  out_valid/out_ready  status, rect_x, rect_y, grow_steps, tex_width, tex_height
// cfg       in   cfg_we               cfg_index, cfg_data
//
// One request at a time. A token walks the row cells, one cell per cycle. If no row
// fits, a new row opens when one is free; the texture doubles while the new row's height
// does not fit, up to the side limit. The length of the row chain bounds the scan.
// Reset (or any config write) empties the row table; row cells need no clearing.
// A finished result sits in the output register; the next transfer on the input
// is taken while it waits.
module glyph_atlas_shelf_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  glyph_width,
    input  logic [9:0]  glyph_height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [11:0] rect_x,
    output logic [11:0] rect_y,
    output logic [3:0]  grow_steps,
    output logic [12:0] tex_width,
    output logic [12:0] tex_height,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_NEW  = 3'd2;
    localparam logic [2:0] S_GROW = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int RC_W = gasp_pkg::ROW_IDX_W + 1;

    logic [2:0]  state_reg, state_next;
    logic [12:0] init_side_reg;
    logic [6:0]  first_top_reg;
    logic [RC_W-1:0] row_count_reg;
    logic [12:0] nfr_reg;
    logic [12:0] cur_w_reg, cur_h_reg;
    logic [9:0]  w_reg, h_reg;
    logic [9:0]  rh_reg;
    logic [12:0] side_w_reg, side_h_reg;
    logic [3:0]  steps_reg;
    logic [gasp_pkg::ROW_IDX_W-1:0] scan_idx_reg;
    logic [2:0]  res_st_reg;
    logic [11:0] res_x_reg, res_y_reg;
    logic [3:0]  res_steps_reg;
    logic        out_valid_reg;
    logic [2:0]  out_st_reg;
    logic [11:0] out_x_reg, out_y_reg;
    logic [3:0]  out_steps_reg;
    logic [12:0] out_tw_reg, out_th_reg;

    logic [12:0] side_clamped;
    logic [19:0] h_div_prod;
    logic [13:0] need_h;
    logic        any_hit;
    logic [11:0] hit_x, hit_y;
    logic        start, go, commit_new, last_row;

    logic [gasp_pkg::MAX_ROWS-1:0] tok_in, tok_out, wr_sel;
    gasp_pkg::cell_req_t req;
    gasp_pkg::cell_rsp_t rsp [gasp_pkg::MAX_ROWS];

    assign in_ready = (state_reg == S_IDLE);
    wire   in_xfer  = in_valid && in_ready;
    wire   out_free = !out_valid_reg || out_ready;

    // Side clamp to [16, MAX_TEX_SIDE]
    always_comb
    begin
        if (cfg_data < 13'd16)
            side_clamped = 13'd16;
        else if (cfg_data > 13'(gasp_pkg::MAX_TEX_SIDE))
            side_clamped = 13'(gasp_pkg::MAX_TEX_SIDE);
        else
            side_clamped = cfg_data;
    end

    wire [12:0] init_clamped = (init_side_reg < 13'd16) ? 13'd16 :
        ((init_side_reg > 13'(gasp_pkg::MAX_TEX_SIDE)) ?
         13'(gasp_pkg::MAX_TEX_SIDE) : init_side_reg);

    // h/10 via reciprocal, exact for h <= MAX_GLYPH
    assign h_div_prod = {10'd0, h_reg} * 20'd205;
    assign need_h     = {1'b0, nfr_reg} + {4'd0, rh_reg};

    // Cell broadcast
    assign req.w         = w_reg;
    assign req.h_x10     = {1'b0, h_reg, 3'b000} + {3'b000, h_reg, 1'b0};
    assign req.cur_width = cur_w_reg;
    assign req.wr_top    = nfr_reg[11:0];
    assign req.wr_height = rh_reg;
    assign req.wr_fill   = {3'd0, w_reg};

    // Token stops at the last live row so it never reaches an unwritten cell
    assign last_row   = ({1'b0, scan_idx_reg} == row_count_reg - RC_W'(1));
    assign go         = (state_reg == S_SCAN) && !any_hit && !last_row;
    assign commit_new = (state_reg == S_GROW) && !(need_h >= {1'b0, side_h_reg})
                        && !({3'd0, w_reg} > side_w_reg);

    genvar gi;
    generate
        for (gi = 0; gi < gasp_pkg::MAX_ROWS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign tok_in[gi] = start;
            end
            else
            begin : g_body
                assign tok_in[gi] = tok_out[gi-1] && go;
            end
            assign wr_sel[gi] = commit_new &&
                (row_count_reg[gasp_pkg::ROW_IDX_W-1:0] == gasp_pkg::ROW_IDX_W'(gi));
            gasp_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_in[gi]),
                .wr_en   (wr_sel[gi]),
                .req     (req),
                .tok_out (tok_out[gi]),
                .rsp     (rsp[gi])
            );
        end
    endgenerate

    // Only the token cell can hit, so an OR picks its data
    always_comb
    begin
        any_hit = 1'b0;
        hit_x   = 12'd0;
        hit_y   = 12'd0;
        for (int i = 0; i < gasp_pkg::MAX_ROWS; i++)
        begin
            any_hit = any_hit | rsp[i].hit;
            hit_x   = hit_x | rsp[i].x;
            hit_y   = hit_y | rsp[i].y;
        end
    end

    wire w_big = glyph_width > 10'(gasp_pkg::MAX_GLYPH);
    wire h_big = glyph_height > 10'(gasp_pkg::MAX_GLYPH);
    assign start = in_xfer && !w_big && !h_big && (row_count_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (w_big || h_big)
                        state_next = S_DONE;
                    else if (row_count_reg == '0)
                        state_next = S_NEW;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (any_hit)
                    state_next = S_DONE;
                else if (last_row)
                    state_next = S_NEW;
            end
            S_NEW:
            begin
                if (row_count_reg >= RC_W'(gasp_pkg::MAX_ROWS))
                    state_next = S_DONE;
                else
                    state_next = S_GROW;
            end
            S_GROW:
            begin
                if (need_h >= {1'b0, side_h_reg})
                begin
                    if (side_h_reg > 13'(gasp_pkg::MAX_TEX_SIDE / 2) ||
                        side_w_reg > 13'(gasp_pkg::MAX_TEX_SIDE / 2))
                        state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_side_reg <= 13'd128;
            first_top_reg <= 7'd2;
            row_count_reg <= '0;
            nfr_reg       <= 13'd2;
            cur_w_reg     <= 13'd128;
            cur_h_reg     <= 13'd128;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                row_count_reg <= '0;
                case (cfg_index)
                    gasp_pkg::CFG_INITIAL_SIDE:
                    begin
                        init_side_reg <= cfg_data;
                        cur_w_reg     <= side_clamped;
                        cur_h_reg     <= side_clamped;
                        nfr_reg       <= {6'd0, first_top_reg};
                    end
                    gasp_pkg::CFG_FIRST_ROW_TOP:
                    begin
                        first_top_reg <= cfg_data[6:0];
                        cur_w_reg     <= init_clamped;
                        cur_h_reg     <= init_clamped;
                        nfr_reg       <= {6'd0, cfg_data[6:0]};
                    end
                    default:
                    begin
                        row_count_reg <= '0;
                    end
                endcase
            end
            else if (commit_new)
            begin
                row_count_reg <= row_count_reg + RC_W'(1);
                nfr_reg       <= need_h[12:0];
                cur_w_reg     <= side_w_reg;
                cur_h_reg     <= side_h_reg;
            end
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            w_reg         <= glyph_width;
            h_reg         <= glyph_height;
            scan_idx_reg  <= '0;
            res_x_reg     <= 12'd0;
            res_y_reg     <= 12'd0;
            res_steps_reg <= 4'd0;
            res_st_reg    <= w_big ? gasp_pkg::ST_TOO_WIDE : gasp_pkg::ST_AT_MAX;
        end
        case (state_reg)
            S_SCAN:
            begin
                scan_idx_reg <= scan_idx_reg + gasp_pkg::ROW_IDX_W'(1);
                if (any_hit)
                begin
                    res_st_reg <= gasp_pkg::ST_OLD_ROW;
                    res_x_reg  <= hit_x;
                    res_y_reg  <= hit_y;
                end
            end
            S_NEW:
            begin
                rh_reg     <= h_reg + {1'b0, h_div_prod[20-1:11]};
                side_w_reg <= cur_w_reg;
                side_h_reg <= cur_h_reg;
                steps_reg  <= 4'd0;
                res_st_reg <= gasp_pkg::ST_ROWS_FULL;
            end
            S_GROW:
            begin
                if (need_h >= {1'b0, side_h_reg})
                begin
                    side_w_reg <= {side_w_reg[11:0], 1'b0};
                    side_h_reg <= {side_h_reg[11:0], 1'b0};
                    steps_reg  <= steps_reg + 4'd1;
                    res_st_reg <= gasp_pkg::ST_AT_MAX;
                end
                else if ({3'd0, w_reg} > side_w_reg)
                begin
                    res_st_reg <= gasp_pkg::ST_TOO_WIDE;
                end
                else
                begin
                    res_st_reg    <= gasp_pkg::ST_NEW_ROW;
                    res_y_reg     <= nfr_reg[11:0];
                    res_steps_reg <= steps_reg;
                end
            end
            default:
            begin
                rh_reg <= rh_reg;
            end
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            out_st_reg    <= res_st_reg;
            out_x_reg     <= res_x_reg;
            out_y_reg     <= res_y_reg;
            out_steps_reg <= res_steps_reg;
            out_tw_reg    <= cur_w_reg;
            out_th_reg    <= cur_h_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_st_reg;
    assign rect_x     = out_x_reg;
    assign rect_y     = out_y_reg;
    assign grow_steps = out_steps_reg;
    assign tex_width  = out_tw_reg;
    assign tex_height = out_th_reg;

    a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_out)) else $error("more than one scan token");
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        any_hit |-> state_reg == S_SCAN) else $error("row hit outside scan");
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= RC_W'(gasp_pkg::MAX_ROWS)) else $error("row count overflow");
    a_new_row_grows: assert property (@(posedge clk) disable iff (!rst_n)
        commit_new |=> row_count_reg == $past(row_count_reg) + RC_W'(1))
        else $error("new row not counted");

endmodule
